/* rtl/bgcm_pkg.sv */
// Shared types and constants for the battery gauge and charge manager.
// No dependencies; used by every module of the block.
package bgcm_pkg;

  localparam int MV_W   = 13;
  localparam int EMV_W  = 12;
  localparam int TEMP_W = 9;
  localparam int PCT_W  = 7;
  localparam int LVL_W  = 2;
  localparam int CODE_W = 6;
  localparam int CNT_W  = 5;
  localparam int PROD_W = 20;
  localparam int IDX_W  = 2;

  localparam logic [IDX_W-1:0] REG_MAX_CHARGE = 2'd0;
  localparam logic [IDX_W-1:0] REG_EMPTY      = 2'd1;
  localparam logic [IDX_W-1:0] REG_PRESENT    = 2'd2;
  localparam logic [IDX_W-1:0] REG_MISSING    = 2'd3;

  localparam logic [MV_W-1:0]   FULL_MV      = 13'd4080;
  localparam logic [TEMP_W-1:0] HOT_K        = 9'd338;
  localparam logic [TEMP_W-1:0] STOP_K       = 9'd343;
  localparam logic [CODE_W-1:0] SAFE_CODE    = 6'h38;
  localparam logic [CODE_W-1:0] TRICKLE_CODE = 6'h07;
  localparam logic [MV_W-1:0]   RAIL_FULL_MV = 13'd4800;
  localparam logic [CNT_W-1:0]  REFRESH_AT   = 5'd20;
  localparam logic [CNT_W-1:0]  CNT_MAX      = 5'd31;
  localparam logic [PCT_W-1:0]  HIGH_PCT     = 7'd65;
  localparam logic [PCT_W-1:0]  LOW_PCT      = 7'd20;
  localparam logic [PCT_W-1:0]  PCT_FULL     = 7'd100;
  localparam logic [CODE_W-1:0] WALL_HI_CODE = 6'h18;
  localparam logic [CODE_W-1:0] WALL_LO_CODE = 6'h10;
  localparam logic [MV_W-1:0]   TRICKLE_MV   = 13'd3200;

  localparam logic [LVL_W-1:0] LVL_HIGH     = 2'd0;
  localparam logic [LVL_W-1:0] LVL_LOW      = 2'd1;
  localparam logic [LVL_W-1:0] LVL_CRITICAL = 2'd2;
  localparam logic [LVL_W-1:0] LVL_CHARGING = 2'd3;

  // Commands from controller to datapath.
  typedef struct packed {
    logic load;       // capture request fields
    logic mul;        // register scaled voltage difference
    logic div_start;  // launch percentage divider
    logic commit;     // update gauge state and charger fields
    logic emit;       // load output register
  } cmd_t;

  // Status from datapath to controller.
  typedef struct packed {
    logic div_last;   // divider performs its final step this cycle
  } status_t;

endpackage

/* rtl/bgcm_div.sv */
// Restoring divider producing a 7-bit quotient, one bit per cycle.
// Depends on bgcm_pkg; the dividend must be below divisor * 128.
module bgcm_div (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          start,
  input  logic [bgcm_pkg::PROD_W-1:0]   dividend,
  input  logic [bgcm_pkg::EMV_W-1:0]    divisor,
  output logic                          last,
  output logic [bgcm_pkg::PCT_W-1:0]    quotient
);
  import bgcm_pkg::*;

  localparam int STEP_W = $clog2(PCT_W);

  logic                  busy;
  logic [STEP_W-1:0]     step;
  logic [PROD_W-1:0]     rem;
  logic [PROD_W-1:0]     dsr;
  logic [PROD_W:0]       trial;

  assign trial = {1'b0, rem} - {1'b0, dsr};
  assign last  = busy && (step == '0);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      step <= '0;
    end else if (start) begin
      busy <= 1'b1;
      step <= STEP_W'(PCT_W - 1);
    end else if (busy) begin
      if (step == '0) begin
        busy <= 1'b0;
      end else begin
        step <= step - 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem      <= dividend;
      dsr      <= PROD_W'({divisor, {(PCT_W-1){1'b0}}});
      quotient <= '0;
    end else if (busy) begin
      // keep the difference when the shifted divisor fits
      if (!trial[PROD_W]) begin
        rem <= trial[PROD_W-1:0];
      end
      quotient <= {quotient[PCT_W-2:0], !trial[PROD_W]};
      dsr      <= dsr >> 1;
    end
  end

endmodule

/* rtl/bgcm_dp.sv */
// Datapath: configuration registers, gauge state, charger decision, output register.
// Depends on bgcm_pkg and bgcm_div.
module bgcm_dp (
  input  logic                          clk,
  input  logic                          rst,
  input  bgcm_pkg::cmd_t                cmd,
  output bgcm_pkg::status_t             status,
  input  logic                          cfg_write,
  input  logic [bgcm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bgcm_pkg::MV_W-1:0]     cfg_data,
  input  logic                          command,
  input  logic                          on_5v_supply,
  input  logic [bgcm_pkg::MV_W-1:0]     battery_mv,
  input  logic [bgcm_pkg::MV_W-1:0]     rail_5v_mv,
  input  logic [bgcm_pkg::TEMP_W-1:0]   die_temp_k,
  output logic                          ac_online,
  output logic [bgcm_pkg::PCT_W-1:0]    life_percent,
  output logic [bgcm_pkg::LVL_W-1:0]    level,
  output logic [bgcm_pkg::MV_W-1:0]     reported_mv,
  output logic                          charger_update,
  output logic                          charger_on,
  output logic [bgcm_pkg::CODE_W-1:0]   charge_current_code
);
  import bgcm_pkg::*;

  // configuration
  logic [MV_W-1:0]   max_charge_mv;
  logic [EMV_W-1:0]  empty_mv;
  logic              battery_present;
  logic              battery_missing;

  // gauge state
  logic [CNT_W-1:0]  refresh_count;
  logic [MV_W-1:0]   last_voltage;
  logic [PCT_W-1:0]  percent_held;
  logic              charging_mark;

  // captured request
  logic              cmd_r;
  logic              ac_r;
  logic [MV_W-1:0]   v_r;
  logic [MV_W-1:0]   rail_r;
  logic [TEMP_W-1:0] temp_r;

  logic [PROD_W-1:0] prod;
  logic [PCT_W-1:0]  quot;
  logic              upd_r;
  logic              on_r;
  logic [CODE_W-1:0] code_r;

  logic [MV_W-1:0]   empty_ext;
  logic [MV_W-1:0]   diff;
  logic [EMV_W-1:0]  span;
  logic              empty_high;
  logic              below_empty;

  logic [CNT_W-1:0]  count_inc;
  logic [CNT_W-1:0]  count_next;
  logic              refresh;
  logic [PCT_W-1:0]  target;
  logic [PCT_W-1:0]  percent_next;
  logic              mark_next;
  logic [CODE_W-1:0] cur;
  logic [CODE_W-1:0] code;
  logic              on_next;
  logic [CODE_W-1:0] code_next;
  logic              charge_req;

  logic [PCT_W-1:0]  pct_rep;
  logic [LVL_W-1:0]  lvl_rep;
  logic [MV_W-1:0]   mv_rep;

  assign empty_ext   = MV_W'(empty_mv);
  assign diff        = v_r - empty_ext;
  assign span        = EMV_W'(FULL_MV - empty_ext);
  assign empty_high  = (empty_ext >= FULL_MV);
  assign below_empty = (v_r < empty_ext);

  bgcm_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (cmd.div_start),
    .dividend (prod),
    .divisor  (span),
    .last     (status.div_last),
    .quotient (quot)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      max_charge_mv   <= 13'd4200;
      empty_mv        <= 12'd3200;
      battery_present <= 1'b1;
      battery_missing <= 1'b0;
    end else if (cfg_write) begin
      unique case (cfg_index)
        REG_MAX_CHARGE: max_charge_mv   <= cfg_data;
        REG_EMPTY:      empty_mv        <= cfg_data[EMV_W-1:0];
        REG_PRESENT:    battery_present <= cfg_data[0];
        REG_MISSING:    battery_missing <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      cmd_r  <= command;
      ac_r   <= on_5v_supply;
      v_r    <= battery_mv;
      rail_r <= rail_5v_mv;
      temp_r <= die_temp_k;
    end
    if (cmd.mul) begin
      prod <= PROD_W'(diff) * PROD_W'(100);
    end
  end

  always_comb begin
    count_inc  = (refresh_count < CNT_MAX) ? refresh_count + 1'b1 : refresh_count;
    count_next = cmd_r ? REFRESH_AT : (battery_present ? count_inc : refresh_count);
    refresh    = cmd_r || (battery_present && (count_inc >= REFRESH_AT));

    if (empty_high) begin
      target = (v_r >= empty_ext) ? PCT_FULL : '0;
    end else if (below_empty) begin
      target = '0;
    end else if (diff >= MV_W'(span)) begin
      target = PCT_FULL;
    end else begin
      target = quot;
    end

    cur = (rail_r >= RAIL_FULL_MV) ? WALL_HI_CODE : WALL_LO_CODE;
    if (temp_r > HOT_K) begin
      cur = WALL_LO_CODE;
    end
    code       = (v_r <= TRICKLE_MV) ? TRICKLE_CODE : cur;
    charge_req = ac_r && (v_r <= max_charge_mv);
    on_next    = charge_req && (temp_r <= STOP_K) && (code <= SAFE_CODE);
    code_next  = on_next ? code : '0;

    percent_next = percent_held;
    if (ac_r && (v_r >= last_voltage)) begin
      if (percent_held <= target) begin
        percent_next = target;
      end
    end else if (!ac_r && (v_r <= last_voltage)) begin
      if (percent_held >= target) begin
        percent_next = target;
      end
    end
    if (ac_r && (v_r >= FULL_MV)) begin
      percent_next = PCT_FULL;
    end
    mark_next = charge_req && (percent_next != PCT_FULL);
    if (below_empty) begin
      percent_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      refresh_count <= 5'd18;
      last_voltage  <= '0;
      percent_held  <= '0;
      charging_mark <= 1'b0;
    end else if (cmd.commit) begin
      if (refresh) begin
        refresh_count <= '0;
        last_voltage  <= v_r;
        percent_held  <= percent_next;
        charging_mark <= mark_next;
      end else begin
        refresh_count <= count_next;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      upd_r  <= refresh;
      on_r   <= refresh && on_next;
      code_r <= refresh ? code_next : '0;
    end
  end

  always_comb begin
    if (battery_present) begin
      pct_rep = percent_held;
      if (charging_mark) begin
        lvl_rep = LVL_CHARGING;
      end else if (percent_held >= HIGH_PCT) begin
        lvl_rep = LVL_HIGH;
      end else if (percent_held >= LOW_PCT) begin
        lvl_rep = LVL_LOW;
      end else begin
        lvl_rep = LVL_CRITICAL;
      end
      mv_rep = last_voltage;
    end else begin
      pct_rep = battery_missing ? '0 : PCT_FULL;
      lvl_rep = LVL_HIGH;
      mv_rep  = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      ac_online           <= ac_r;
      life_percent        <= pct_rep;
      level               <= lvl_rep;
      reported_mv         <= mv_rep;
      charger_update      <= upd_r;
      charger_on          <= on_r;
      charge_current_code <= code_r;
    end
  end

endmodule

/* rtl/bgcm_ctrl.sv */
// Controller state machine: sequences capture, multiply, divide, commit and output.
// Depends on bgcm_pkg.
module bgcm_ctrl (
  input  logic                clk,
  input  logic                rst,
  input  logic                in_valid,
  output logic                in_stall,
  output logic                out_valid,
  input  logic                out_stall,
  input  bgcm_pkg::status_t   status,
  output bgcm_pkg::cmd_t      cmd
);
  import bgcm_pkg::*;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_MUL    = 3'd1;
  localparam logic [2:0] ST_DSTART = 3'd2;
  localparam logic [2:0] ST_DIV    = 3'd3;
  localparam logic [2:0] ST_COMMIT = 3'd4;
  localparam logic [2:0] ST_EMIT   = 3'd5;

  logic [2:0] state;
  logic [2:0] state_next;
  logic       out_free;

  assign in_stall = (state != ST_IDLE);
  assign out_free = !out_valid || !out_stall;

  always_comb begin
    state_next    = state;
    cmd           = '0;
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.load   = 1'b1;
          state_next = ST_MUL;
        end
      end
      ST_MUL: begin
        cmd.mul    = 1'b1;
        state_next = ST_DSTART;
      end
      ST_DSTART: begin
        cmd.div_start = 1'b1;
        state_next    = ST_DIV;
      end
      ST_DIV: begin
        if (status.div_last) begin
          state_next = ST_COMMIT;
        end
      end
      ST_COMMIT: begin
        cmd.commit = 1'b1;
        state_next = ST_EMIT;
      end
      ST_EMIT: begin
        // hold until the output register is free
        if (out_free) begin
          cmd.emit   = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

`ifndef ASSERT_OFF
  a_accept_to_mul: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> (state == ST_MUL))
    else $error("accepted request did not advance to multiply");

  a_emit_free: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || !out_stall))
    else $error("output register overwritten while held");

  a_div_in_state: assert property (@(posedge clk) disable iff (rst)
    status.div_last |-> (state == ST_DIV))
    else $error("divider finished outside divide state");

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |=> out_valid)
    else $error("output valid missing after emit");
`endif

endmodule

/* rtl/battery_gauge_charge_manager_core.sv */
// Top level of the battery gauge and charge manager.
// Depends on bgcm_pkg, bgcm_ctrl and bgcm_dp.
//
//  channel  | handshake             | payload
//  ---------+-----------------------+---------------------------------------------
//  input    | in_valid / in_stall   | command, on_5v_supply, battery_mv, rail_5v_mv,
//           |                       | die_temp_k
//  output   | out_valid / out_stall | ac_online, life_percent, level, reported_mv,
//           |                       | charger_update, charger_on, charge_current_code
//  config   | cfg_valid / cfg_ready | cfg_index, cfg_data
//
// Each request steps through the multiply, divider-start, divide, commit and emit
// states after acceptance before its result is valid; the divide state waits on the
// restoring divider for the percentage. A new request is taken once the previous one
// is in the output register, even while it is stalled.
// Reset (rst, synchronous) restores register defaults and gauge state.
// Output stall holds the result register; the next result then waits in the FSM.
module battery_gauge_charge_manager_core (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic                          command,
  input  logic                          on_5v_supply,
  input  logic [bgcm_pkg::MV_W-1:0]     battery_mv,
  input  logic [bgcm_pkg::MV_W-1:0]     rail_5v_mv,
  input  logic [bgcm_pkg::TEMP_W-1:0]   die_temp_k,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          ac_online,
  output logic [bgcm_pkg::PCT_W-1:0]    life_percent,
  output logic [bgcm_pkg::LVL_W-1:0]    level,
  output logic [bgcm_pkg::MV_W-1:0]     reported_mv,
  output logic                          charger_update,
  output logic                          charger_on,
  output logic [bgcm_pkg::CODE_W-1:0]   charge_current_code,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [bgcm_pkg::IDX_W-1:0]    cfg_index,
  input  logic [bgcm_pkg::MV_W-1:0]     cfg_data
);
  import bgcm_pkg::*;

  cmd_t    cmd;
  status_t status;

  assign cfg_ready = 1'b1;

  bgcm_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .status    (status),
    .cmd       (cmd)
  );

  bgcm_dp u_dp (
    .clk                 (clk),
    .rst                 (rst),
    .cmd                 (cmd),
    .status              (status),
    .cfg_write           (cfg_valid && cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .command             (command),
    .on_5v_supply        (on_5v_supply),
    .battery_mv          (battery_mv),
    .rail_5v_mv          (rail_5v_mv),
    .die_temp_k          (die_temp_k),
    .ac_online           (ac_online),
    .life_percent        (life_percent),
    .level               (level),
    .reported_mv         (reported_mv),
    .charger_update      (charger_update),
    .charger_on          (charger_on),
    .charge_current_code (charge_current_code)
  );

endmodule

/* tb/bgcm_checker.sv */
// Checker for the battery gauge and charge manager: watches the request,
// result and register channels, predicts each result and compares it.
// Depends on bgcm_pkg for widths, register indexes and gauge constants.
module bgcm_checker (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        in_valid,
  input  logic                        in_stall,
  input  logic                        command,
  input  logic                        on_5v_supply,
  input  logic [bgcm_pkg::MV_W-1:0]   battery_mv,
  input  logic [bgcm_pkg::MV_W-1:0]   rail_5v_mv,
  input  logic [bgcm_pkg::TEMP_W-1:0] die_temp_k,
  input  logic                        out_valid,
  input  logic                        out_stall,
  input  logic                        ac_online,
  input  logic [bgcm_pkg::PCT_W-1:0]  life_percent,
  input  logic [bgcm_pkg::LVL_W-1:0]  level,
  input  logic [bgcm_pkg::MV_W-1:0]   reported_mv,
  input  logic                        charger_update,
  input  logic                        charger_on,
  input  logic [bgcm_pkg::CODE_W-1:0] charge_current_code,
  input  logic                        cfg_valid,
  input  logic                        cfg_ready,
  input  logic [bgcm_pkg::IDX_W-1:0]  cfg_index,
  input  logic [bgcm_pkg::MV_W-1:0]   cfg_data,
  output int                          mismatches,
  output int                          checked,
  output int                          outstanding
);
  timeunit 1ns;
  timeprecision 1ps;
  import bgcm_pkg::*;

  typedef struct packed {
    logic              ac;
    logic [PCT_W-1:0]  pct;
    logic [LVL_W-1:0]  lvl;
    logic [MV_W-1:0]   mv;
    logic              upd;
    logic              on;
    logic [CODE_W-1:0] code;
  } gauge_status_t;

  // register shadows
  logic [MV_W-1:0]  max_charge;
  logic [EMV_W-1:0] empty_level;
  logic             present;
  logic             missing;

  // gauge state shadows
  logic [CNT_W-1:0] poll_count;
  logic [MV_W-1:0]  last_mv;
  logic [PCT_W-1:0] pct_held;
  logic             charge_mark;

  gauge_status_t pending_status[$];

  function automatic int charge_target(input logic [MV_W-1:0] v);
    int e;
    int p;
    e = int'(empty_level);
    if (e >= int'(FULL_MV)) return (int'(v) >= e) ? 100 : 0;
    if (int'(v) < e) return 0;
    p = ((int'(v) - e) * 100) / (int'(FULL_MV) - e);
    return (p > 100) ? 100 : p;
  endfunction

  // Advance the gauge state by one request and return the status it reports.
  function automatic gauge_status_t gauge_status(input logic cmd, input logic ac,
                                                 input logic [MV_W-1:0] v,
                                                 input logic [MV_W-1:0] rail,
                                                 input logic [TEMP_W-1:0] temp);
    gauge_status_t r;
    logic refresh;
    logic [CODE_W-1:0] wall_code;
    logic [CODE_W-1:0] code;
    int tgt;
    r = '0;
    refresh = 1'b0;
    if (cmd) begin
      poll_count = REFRESH_AT;
      refresh = 1'b1;
    end else if (present) begin
      if (poll_count < CNT_MAX) poll_count = poll_count + 1'b1;
      refresh = (poll_count >= REFRESH_AT);
    end
    if (refresh) begin
      wall_code = (rail >= RAIL_FULL_MV) ? WALL_HI_CODE : WALL_LO_CODE;
      if (temp > HOT_K) wall_code = WALL_LO_CODE;
      r.upd = 1'b1;
      charge_mark = 1'b0;
      poll_count = '0;
      if (ac && v <= max_charge) begin
        code = (v <= TRICKLE_MV) ? TRICKLE_CODE : wall_code;
        // an overheated die keeps the charger off but still marks charging
        if (temp <= STOP_K && code <= SAFE_CODE) begin
          r.on = 1'b1;
          r.code = code;
        end
        charge_mark = 1'b1;
      end
      tgt = charge_target(v);
      // percentage only rises on AC and only falls on battery
      if (ac && v >= last_mv) begin
        if (int'(pct_held) <= tgt) pct_held = tgt[PCT_W-1:0];
      end else if (!ac && v <= last_mv) begin
        if (int'(pct_held) >= tgt) pct_held = tgt[PCT_W-1:0];
      end
      if (ac && v >= FULL_MV) pct_held = PCT_FULL;
      if (pct_held == PCT_FULL) charge_mark = 1'b0;
      if (v < {1'b0, empty_level}) pct_held = '0;
      last_mv = v;
    end
    r.ac = ac;
    if (present) begin
      r.pct = pct_held;
      if (pct_held >= HIGH_PCT) r.lvl = LVL_HIGH;
      else if (pct_held >= LOW_PCT) r.lvl = LVL_LOW;
      else r.lvl = LVL_CRITICAL;
      if (charge_mark) r.lvl = LVL_CHARGING;
      r.mv = last_mv;
    end else begin
      r.pct = missing ? '0 : PCT_FULL;
      r.lvl = LVL_HIGH;
      r.mv = '0;
    end
    return r;
  endfunction

  always @(posedge clk) begin
    gauge_status_t got;
    gauge_status_t want;
    if (rst) begin
      max_charge <= 13'd4200;
      empty_level <= 12'd3200;
      present <= 1'b1;
      missing <= 1'b0;
      poll_count = 5'd18;
      last_mv = '0;
      pct_held = '0;
      charge_mark = 1'b0;
      pending_status.delete();
      mismatches <= 0;
      checked <= 0;
      outstanding <= 0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_MAX_CHARGE: max_charge <= cfg_data;
          REG_EMPTY:      empty_level <= cfg_data[EMV_W-1:0];
          REG_PRESENT:    present <= cfg_data[0];
          REG_MISSING:    missing <= cfg_data[0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        pending_status.push_back(gauge_status(command, on_5v_supply, battery_mv,
                                              rail_5v_mv, die_temp_k));
      if (out_valid && !out_stall) begin
        got = '{ac_online, life_percent, level, reported_mv, charger_update,
                charger_on, charge_current_code};
        checked <= checked + 1;
        if (pending_status.size() == 0) begin
          if (mismatches < 10)
            $display("%0t: result with no request waiting: pct=%0d lvl=%0d mv=%0d",
                     $realtime, got.pct, got.lvl, got.mv);
          mismatches <= mismatches + 1;
        end else begin
          want = pending_status.pop_front();
          if (got !== want) begin
            if (mismatches < 10)
              $display({"%0t: result %0d differs\n",
                        "  expected ac=%0d pct=%0d lvl=%0d mv=%0d upd=%0d on=%0d code=%0d\n",
                        "  actual   ac=%0d pct=%0d lvl=%0d mv=%0d upd=%0d on=%0d code=%0d"},
                       $realtime, checked,
                       want.ac, want.pct, want.lvl, want.mv, want.upd, want.on, want.code,
                       got.ac, got.pct, got.lvl, got.mv, got.upd, got.on, got.code);
            mismatches <= mismatches + 1;
          end
        end
      end
      outstanding <= pending_status.size();
    end
  end

endmodule

/* tb/testbench.sv */
// Top of the battery gauge and charge manager testbench: clock, reset,
// request and register stimulus, result-side stalls and the verdict.
// Depends on bgcm_pkg, battery_gauge_charge_manager_core and bgcm_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;
  import bgcm_pkg::*;

  localparam int DRAIN_CYCLES = 30;

  logic              clk;
  logic              rst;
  logic              in_valid;
  logic              in_stall;
  logic              command;
  logic              on_5v_supply;
  logic [MV_W-1:0]   battery_mv;
  logic [MV_W-1:0]   rail_5v_mv;
  logic [TEMP_W-1:0] die_temp_k;
  logic              out_valid;
  logic              out_stall;
  logic              ac_online;
  logic [PCT_W-1:0]  life_percent;
  logic [LVL_W-1:0]  level;
  logic [MV_W-1:0]   reported_mv;
  logic              charger_update;
  logic              charger_on;
  logic [CODE_W-1:0] charge_current_code;
  logic              cfg_valid;
  logic              cfg_ready;
  logic [IDX_W-1:0]  cfg_index;
  logic [MV_W-1:0]   cfg_data;

  int mismatches;
  int checked;
  int outstanding;

  bit calm;
  int requests_sent;
  int events_sent;
  int settings_used;
  int event_pct;
  int walk_mv;
  bit walk_ac;

  battery_gauge_charge_manager_core dut (.*);

  bgcm_checker gauge_chk (.*);

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // result-side stall bursts
  initial begin
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (!calm && $urandom_range(0, 4) == 0) begin
        out_stall <= 1'b1;
        repeat ($urandom_range(1, 3)) @(posedge clk);
        out_stall <= 1'b0;
      end
    end
  end

  initial begin
    #500000;
    $display("Timeout with %0d results still expected", outstanding);
    $display("Mismatches found");
    $finish;
  end

  task automatic send(input logic cmd, input logic ac, input int v, input int rail,
                      input int temp);
    if (!calm && $urandom_range(0, 3) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 3)) @(posedge clk);
    end
    in_valid <= 1'b1;
    command <= cmd;
    on_5v_supply <= ac;
    battery_mv <= v[MV_W-1:0];
    rail_5v_mv <= rail[MV_W-1:0];
    die_temp_k <= temp[TEMP_W-1:0];
    @(posedge clk);
    while (in_stall) @(posedge clk);
    requests_sent++;
    if (cmd) events_sent++;
  endtask

  task automatic send_random();
    logic cmd;
    int pick;
    int v;
    int rail;
    int temp;
    cmd = ($urandom_range(0, 99) < event_pct);
    if ($urandom_range(0, 9) == 0) walk_ac = !walk_ac;
    // drift the battery the way the supply pushes it
    if (walk_ac) walk_mv = walk_mv + int'($urandom_range(0, 40));
    else walk_mv = walk_mv - int'($urandom_range(0, 40));
    if (walk_mv > 4500) walk_mv = 4500;
    if (walk_mv < 2300) walk_mv = 2300;
    pick = $urandom_range(0, 99);
    if (pick < 80) v = walk_mv;
    else if (pick < 92) v = $urandom_range(0, 5000);
    else if (pick < 97) v = $urandom_range(0, 8191);
    else v = pick[0] ? 0 : 8191;
    pick = $urandom_range(0, 99);
    if (pick < 70) rail = $urandom_range(4600, 5200);
    else if (pick < 90) rail = $urandom_range(0, 5200);
    else rail = $urandom_range(0, 8191);
    pick = $urandom_range(0, 99);
    if (pick < 80) temp = $urandom_range(300, 350);
    else if (pick < 95) temp = $urandom_range(273, 353);
    else temp = $urandom_range(0, 511);
    send(cmd, walk_ac, v, rail, temp);
  endtask

  task automatic run_random(input int count);
    for (int i = 0; i < count; i++) begin
      // every 25 requests, pick a poll-heavy or an event-heavy stretch at random
      if (i % 25 == 0) event_pct = $urandom_range(0, 1) ? 5 : 40;
      send_random();
    end
  endtask

  task automatic wait_idle();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_reg(input logic [IDX_W-1:0] idx, input logic [MV_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
  endtask

  task automatic set_config(input int max_mv, input int empty, input bit present,
                            input bit missing);
    logic [MV_W-1:0] noise;
    wait_idle();
    noise = MV_W'($urandom);
    write_reg(REG_MAX_CHARGE, max_mv[MV_W-1:0]);
    // unused upper bits carry noise and must be dropped
    write_reg(REG_EMPTY, {noise[MV_W-1], empty[EMV_W-1:0]});
    write_reg(REG_PRESENT, {noise[MV_W-1:1], present});
    write_reg(REG_MISSING, {noise[MV_W-2:0], missing});
    cfg_valid <= 1'b0;
    settings_used++;
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    command = 1'b0;
    on_5v_supply = 1'b0;
    battery_mv = '0;
    rail_5v_mv = '0;
    die_temp_k = '0;
    cfg_valid = 1'b0;
    cfg_index = REG_MAX_CHARGE;
    cfg_data = '0;
    calm = 1'b0;
    walk_mv = 3600;
    walk_ac = 1'b1;
    event_pct = 10;
    repeat (6) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // power-on defaults first: polls reach the refresh threshold
    send(1'b0, 1'b0, 3700, 5000, 300);
    send(1'b0, 1'b1, 3700, 5000, 300);
    send(1'b1, 1'b1, 3000, 5000, 300);   // trickle current, below empty
    send(1'b1, 1'b1, 3900, 4800, 339);   // hot die drops to low current
    send(1'b1, 1'b1, 3950, 4799, 343);
    send(1'b1, 1'b1, 4100, 5000, 344);   // too hot: charger stays off, full battery
    send(1'b1, 1'b1, 4300, 5000, 300);   // above charge limit
    send(1'b1, 1'b0, 3772, 5000, 300);   // level thresholds on the way down
    send(1'b1, 1'b0, 3771, 5000, 300);
    send(1'b1, 1'b0, 3376, 5000, 300);
    send(1'b1, 1'b0, 3375, 5000, 300);
    send(1'b1, 1'b0, 3500, 5000, 300);   // rising on battery: hold percentage
    send(1'b1, 1'b1, 3200, 5200, 338);
    send(1'b1, 1'b1, 4080, 5000, 273);
    send(1'b1, 1'b0, 8191, 8191, 511);
    send(1'b1, 1'b1, 0, 0, 0);
    send(1'b1, 1'b1, 4200, 5000, 300);
    run_random(100);

    set_config(4400, 2400, 1'b1, 1'b0);
    run_random(70);
    set_config(0, 4095, 1'b1, 1'b1);
    send(1'b1, 1'b1, 4095, 5000, 300);
    send(1'b1, 1'b0, 4094, 5000, 300);
    run_random(40);
    set_config(8191, 0, 1'b1, 1'b0);
    run_random(50);
    set_config(3000, 4000, 1'b0, 1'b0);
    run_random(40);
    set_config(4200, 4080, 1'b0, 1'b1);
    run_random(40);
    set_config(4200, 3200, 1'b1, 1'b0);
    run_random(50);
    // finish without idling on either side
    calm = 1'b1;
    run_random(60);

    wait_idle();
    repeat (DRAIN_CYCLES) @(posedge clk);
    $display("Sent %0d requests (%0d supply events) across %0d register settings",
             requests_sent, events_sent, settings_used);
    $display("Checked %0d results", checked);
    if (mismatches == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
